// File: rtl/ascp_pkg.sv
// ----------------------------------------------------------------------------
// ASCII setpoint command parser package
// Shared constants, character codes and request/result types.
// ----------------------------------------------------------------------------
`default_nettype none

package ascp_pkg;

   localparam int MAX_VALUE_CHARS_DEFAULT = 10;

   localparam int POS_WIDTH  = 4;
   localparam int ACC_WIDTH  = 34;
   localparam int MANT_WIDTH = 35;
   localparam int FRAC_WIDTH = 4;
   localparam int KIND_WIDTH = 2;
   localparam int ID_WIDTH   = 4;

   localparam logic [7:0] CHAR_M       = 8'h4D;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_P       = 8'h50;
   localparam logic [7:0] CHAR_S       = 8'h53;
   localparam logic [7:0] CHAR_C       = 8'h43;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_POINT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [KIND_WIDTH-1:0] KIND_POSITION = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_SPEED    = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_CURRENT  = 2'd2;

   localparam logic [0:0] MODE_BYTE = 1'b0;
   localparam logic [0:0] MODE_IDLE = 1'b1;

   localparam logic [FRAC_WIDTH-1:0] NO_POINT   = 4'd15;
   localparam logic [FRAC_WIDTH-1:0] POINT_SAT  = 4'd14;
   localparam logic [POS_WIDTH-1:0]  HEADER_LEN = 4'd4;
   localparam logic [POS_WIDTH-1:0]  POS_MAX    = 4'd15;
   localparam logic [ID_WIDTH-1:0]   DEVICE_ID_RESET = 4'd1;

   typedef struct packed {
      logic       mode;
      logic [7:0] rx_byte;
   } ascp_req_type;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]        target_kind;
      logic signed [MANT_WIDTH-1:0] mantissa;
      logic [FRAC_WIDTH-1:0]        fraction_digits;
   } ascp_cmd_type;

endpackage

`default_nettype wire

// File: rtl/ascp_in_stage.sv
// ----------------------------------------------------------------------------
// ASCII setpoint command parser input stage
// Registers one request and hands it on when the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ascp_in_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  ascp_pkg::ascp_req_type in_data,
   input  wire                  consume,
   output logic                 out_valid,
   output ascp_pkg::ascp_req_type out_data
);
   import ascp_pkg::*;

   logic         valid_ff, valid_in;
   ascp_req_type data_ff, data_in;
   logic         load;

   assign in_ready = !valid_ff || consume;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = in_data;
      end else if (consume) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/ascp_parse.sv
// ----------------------------------------------------------------------------
// ASCII setpoint command parser frame state
// Holds the frame state and the device number, decodes one byte per cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ascp_parse #(
   parameter int MAX_VALUE_CHARS = ascp_pkg::MAX_VALUE_CHARS_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_we,
   input  wire [ascp_pkg::ID_WIDTH-1:0]       csr_wdata,
   input  wire                                step,
   input  ascp_pkg::ascp_req_type             req,
   output logic                               cmd_valid,
   output ascp_pkg::ascp_cmd_type             cmd
);
   import ascp_pkg::*;

   localparam logic [POS_WIDTH-1:0] LAST_VALUE_POS = POS_WIDTH'(MAX_VALUE_CHARS - 1);

   logic [ID_WIDTH-1:0]   device_id_ff, device_id_in;
   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic                  header_ok_ff, header_ok_in;
   logic [KIND_WIDTH-1:0] kind_ff, kind_in;
   logic                  neg_ff, neg_in;
   logic [ACC_WIDTH-1:0]  acc_ff, acc_in;
   logic [FRAC_WIDTH-1:0] point_ff, point_in;
   logic                  ended_ff, ended_in;
   logic                  bad_ff, bad_in;

   logic [POS_WIDTH-1:0]  value_pos;
   logic [7:0]            b;
   logic [7:0]            id_char;
   logic [3:0]            digit;
   logic                  is_digit;
   logic [ACC_WIDTH-1:0]  acc_times_ten;
   logic [MANT_WIDTH-1:0] acc_wide;

   assign b             = req.rx_byte;
   assign value_pos     = pos_ff - HEADER_LEN;
   assign id_char       = CHAR_ZERO + {4'b0000, device_id_ff};
   assign is_digit      = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign digit         = 4'(b - CHAR_ZERO);
   assign acc_times_ten = (acc_ff << 3) + (acc_ff << 1);
   assign acc_wide      = {1'b0, acc_ff};

   always_comb begin
      pos_in       = pos_ff;
      header_ok_in = header_ok_ff;
      kind_in      = kind_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      point_in     = point_ff;
      ended_in     = ended_ff;
      bad_in       = bad_ff;
      cmd_valid    = 1'b0;

      cmd.target_kind     = kind_ff;
      cmd.mantissa        = neg_ff ? -acc_wide : acc_wide;
      cmd.fraction_digits = (point_ff == NO_POINT) ? '0 : point_ff;

      if (step) begin
         if (req.mode == MODE_IDLE) begin
            cmd_valid    = (pos_ff >= HEADER_LEN) && header_ok_ff && !bad_ff;
            pos_in       = '0;
            header_ok_in = 1'b0;
            kind_in      = KIND_POSITION;
            neg_in       = 1'b0;
            acc_in       = '0;
            point_in     = NO_POINT;
            ended_in     = 1'b0;
            bad_in       = 1'b0;
         end else if (!ended_ff) begin
            if (pos_ff < HEADER_LEN) begin
               pos_in = pos_ff + 1'b1;
               case (pos_ff[1:0])
                  2'd0: begin
                     header_ok_in = (b == CHAR_M);
                  end
                  2'd1: begin
                     header_ok_in = header_ok_ff && (b == id_char);
                  end
                  2'd2: begin
                     if (b == CHAR_P) begin
                        kind_in = KIND_POSITION;
                     end else if (b == CHAR_S) begin
                        kind_in = KIND_SPEED;
                     end else if (b == CHAR_C) begin
                        kind_in = KIND_CURRENT;
                     end else begin
                        kind_in      = KIND_POSITION;
                        header_ok_in = 1'b0;
                     end
                  end
                  default: begin
                     header_ok_in = header_ok_ff && (b == CHAR_COLON);
                  end
               endcase
            end else if (b == CHAR_NEWLINE) begin
               ended_in = 1'b1;
            end else begin
               if ((value_pos == '0) && (b == CHAR_MINUS)) begin
                  neg_in = 1'b1;
               end else if (is_digit) begin
                  acc_in = acc_times_ten + {{(ACC_WIDTH-4){1'b0}}, digit};
                  if (point_ff < POINT_SAT) begin
                     point_in = point_ff + 1'b1;
                  end
               end else if (b == CHAR_POINT) begin
                  point_in = '0;
               end else begin
                  bad_in = 1'b1;
               end
               if (value_pos >= LAST_VALUE_POS) begin
                  ended_in = 1'b1;
               end else if (pos_ff < POS_MAX) begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end
      end
   end

   assign device_id_in = csr_we ? csr_wdata : device_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= DEVICE_ID_RESET;
         pos_ff       <= '0;
         header_ok_ff <= 1'b0;
         kind_ff      <= KIND_POSITION;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         point_ff     <= NO_POINT;
         ended_ff     <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         device_id_ff <= device_id_in;
         pos_ff       <= pos_in;
         header_ok_ff <= header_ok_in;
         kind_ff      <= kind_in;
         neg_ff       <= neg_in;
         acc_ff       <= acc_in;
         point_ff     <= point_in;
         ended_ff     <= ended_in;
         bad_ff       <= bad_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ascp_out_stage.sv
// ----------------------------------------------------------------------------
// ASCII setpoint command parser result stage
// Holds one command until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ascp_out_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  wire                    load_valid,
   input  ascp_pkg::ascp_cmd_type load_data,
   output logic                   can_load,
   output logic                   out_valid,
   input  wire                    out_ready,
   output ascp_pkg::ascp_cmd_type out_data
);
   import ascp_pkg::*;

   logic         valid_ff, valid_in;
   ascp_cmd_type data_ff, data_in;

   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = load_valid;
         data_in  = load_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: rtl/ascii_setpoint_command_parser_unit.sv
// ----------------------------------------------------------------------------
// ASCII setpoint command parser
// Parses setpoint command frames from received characters into commands.
// ----------------------------------------------------------------------------
// The unit takes one request per clock unless stalled and gives a command
// for each line-idle request that closes a valid frame. Each request passes
// an input register, is decoded against the frame state combinationally and
// lands in a result register; the rate is set by the frame state update.
// While a command is held in the result register by rsp_tready low, the parser
// stops and at most one more request is taken into the input register.
`default_nettype none

module ascii_setpoint_command_parser_unit #(
   parameter int MAX_VALUE_CHARS = ascp_pkg::MAX_VALUE_CHARS_DEFAULT
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        csr_we,
   input  wire  [3:0] csr_wdata,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,   // [7:0] rx_byte
   input  wire  [0:0] req_tuser,   // [0] mode
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [39:0] rsp_tdata,  // [34:0] mantissa, [38:35] fraction_digits, [39] zero
   output logic [1:0] rsp_tuser    // [1:0] target_kind
);
   import ascp_pkg::*;

   ascp_req_type req_in, req_stage;
   ascp_cmd_type cmd, cmd_out;
   logic         stage_valid;
   logic         out_can_load;
   logic         step;
   logic         cmd_valid;

   assign req_in.mode    = req_tuser[0];
   assign req_in.rx_byte = req_tdata;

   assign step = stage_valid && out_can_load;

   ascp_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_in),
      .consume   (step),
      .out_valid (stage_valid),
      .out_data  (req_stage)
   );

   ascp_parse #(
      .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step      (step),
      .req       (req_stage),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   ascp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .load_valid (cmd_valid),
      .load_data  (cmd),
      .can_load   (out_can_load),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (cmd_out)
   );

   assign rsp_tdata = {1'b0, cmd_out.fraction_digits, cmd_out.mantissa};
   assign rsp_tuser = cmd_out.target_kind;

endmodule

`default_nettype wire

// File: rtl/ascp_checker.sv
// ----------------------------------------------------------------------------
// ASCII setpoint command parser checker
// Port-level checks on the command output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ascp_checker #(
   parameter int MAX_VALUE_CHARS = ascp_pkg::MAX_VALUE_CHARS_DEFAULT
) (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [39:0] rsp_tdata,
   input wire [1:0]  rsp_tuser
);
   import ascp_pkg::*;

   localparam logic [FRAC_WIDTH-1:0] MAX_FRAC = FRAC_WIDTH'(MAX_VALUE_CHARS);

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("Command valid right after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled command changed or vanished.");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_POSITION) || (rsp_tuser == KIND_SPEED)
                     || (rsp_tuser == KIND_CURRENT))
      else $error("Command carries an unknown target kind.");

   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[38:35] <= MAX_FRAC) && !rsp_tdata[39])
      else $error("Fraction digit count exceeds the value length.");

endmodule

bind ascii_setpoint_command_parser_unit ascp_checker #(
   .MAX_VALUE_CHARS (MAX_VALUE_CHARS)
) u_ascp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// ASCII setpoint command parser testbench
// Sends character and line-idle requests in bursts and predicts each command.
// The checker compares every command with the oldest prediction, field by
// field, under random receiver stalls and several device identifiers.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import ascp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LATENCY     = 2;

   typedef logic [7:0] char_q_type[$];

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [3:0]  csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic [0:0]  req_tuser  = MODE_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   logic [ID_WIDTH-1:0]   node_id;
   logic [POS_WIDTH-1:0]  frame_pos;
   logic                  header_good;
   logic [KIND_WIDTH-1:0] frame_kind;
   logic                  is_negative;
   logic [ACC_WIDTH-1:0]  digits_value;
   logic [FRAC_WIDTH-1:0] frac_count;
   logic                  value_closed;
   logic                  illegal_seen;

   ascp_cmd_type        expected_cmds[$];
   int                  error_count     = 0;
   int                  cycles          = 0;
   int                  items_sent      = 0;
   int                  burst_left      = 0;
   int                  ready_left      = 0;
   bit                  ready_now       = 1'b1;
   bit                  sender_idles    = 1'b0;
   bit                  receiver_stalls = 1'b0;
   logic [ID_WIDTH-1:0] active_id       = DEVICE_ID_RESET;

   always #4 clock = ~clock;

   ascii_setpoint_command_parser_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic void clear_frame_state();
      frame_pos    = '0;
      header_good  = 1'b0;
      frame_kind   = KIND_POSITION;
      is_negative  = 1'b0;
      digits_value = '0;
      frac_count   = NO_POINT;
      value_closed = 1'b0;
      illegal_seen = 1'b0;
   endfunction

   function automatic void parse_header_char(logic [7:0] ch);
      case (frame_pos)
         4'd0: header_good = (ch == CHAR_M);
         4'd1: header_good = header_good && (ch == 8'(CHAR_ZERO + node_id));
         4'd2: begin
            case (ch)
               CHAR_P: frame_kind = KIND_POSITION;
               CHAR_S: frame_kind = KIND_SPEED;
               CHAR_C: frame_kind = KIND_CURRENT;
               default: begin
                  frame_kind  = KIND_POSITION;
                  header_good = 1'b0;
               end
            endcase
         end
         default: header_good = header_good && (ch == CHAR_COLON);
      endcase
      frame_pos = frame_pos + 1'b1;
   endfunction

   function automatic void parse_value_char(logic [7:0] ch);
      logic [POS_WIDTH-1:0] slot;
      slot = frame_pos - HEADER_LEN;
      if (ch == CHAR_NEWLINE) begin
         value_closed = 1'b1;
         return;
      end
      if (slot == 0 && ch == CHAR_MINUS) begin
         is_negative = 1'b1;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         digits_value = ACC_WIDTH'(digits_value * 34'd10 + ACC_WIDTH'(ch - CHAR_ZERO));
         if (frac_count < POINT_SAT) frac_count = frac_count + 1'b1;
      end else if (ch == CHAR_POINT) begin
         frac_count = '0;
      end else begin
         illegal_seen = 1'b1;
      end
      if (int'(slot) + 1 >= MAX_VALUE_CHARS_DEFAULT) begin
         value_closed = 1'b1;
      end else if (frame_pos < POS_MAX) begin
         frame_pos = frame_pos + 1'b1;
      end
   endfunction

   function automatic void parse_request(logic mode, logic [7:0] ch);
      ascp_cmd_type         cmd;
      logic [MANT_WIDTH-1:0] mant;
      if (mode == MODE_IDLE) begin
         if (frame_pos >= HEADER_LEN && header_good && !illegal_seen) begin
            mant = {1'b0, digits_value};
            if (is_negative) mant = -mant;
            cmd.target_kind     = frame_kind;
            cmd.mantissa        = mant;
            cmd.fraction_digits = (frac_count == NO_POINT) ? '0 : frac_count;
            expected_cmds.push_back(cmd);
         end
         clear_frame_state();
      end else if (!value_closed) begin
         if (frame_pos < HEADER_LEN) parse_header_char(ch);
         else parse_value_char(ch);
      end
   endfunction

   always @(posedge clock) begin
      ascp_cmd_type want;
      if (reset) begin
         node_id = DEVICE_ID_RESET;
         clear_frame_state();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cmds.size() == 0) begin
               $display("%0t: unexpected command, expected none, actual kind %0d mantissa %0d fraction %0d",
                        $time, rsp_tuser, $signed(rsp_tdata[34:0]), rsp_tdata[38:35]);
               error_count++;
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_tuser !== want.target_kind) begin
                  $display("%0t: target_kind expected %0d actual %0d",
                           $time, want.target_kind, rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[34:0] !== want.mantissa) begin
                  $display("%0t: mantissa expected %0d actual %0d",
                           $time, want.mantissa, $signed(rsp_tdata[34:0]));
                  error_count++;
               end
               if (rsp_tdata[38:35] !== want.fraction_digits) begin
                  $display("%0t: fraction_digits expected %0d actual %0d",
                           $time, want.fraction_digits, rsp_tdata[38:35]);
                  error_count++;
               end
               if (rsp_tdata[39] !== 1'b0) begin
                  $display("%0t: padding bit expected 0 actual %b", $time, rsp_tdata[39]);
                  error_count++;
               end
            end
         end
         if (csr_we) node_id = csr_wdata;
         if (req_tvalid && req_tready) parse_request(req_tuser[0], req_tdata);
      end
   end

   always @(negedge clock) begin
      if (!receiver_stalls) begin
         rsp_tready <= 1'b1;
      end else if (ready_left == 0) begin
         ready_now  = !ready_now;
         ready_left = ready_now ? $urandom_range(1, 12) : $urandom_range(1, 8);
         rsp_tready <= ready_now;
      end else begin
         ready_left--;
         rsp_tready <= ready_now;
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_request(input logic mode, input logic [7:0] ch);
      int gap;
      @(negedge clock);
      if (sender_idles && burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= mode;
      items_sent++;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_frame(input char_q_type chars);
      foreach (chars[i]) send_request(MODE_BYTE, chars[i]);
      send_request(MODE_IDLE, 8'($urandom_range(0, 255)));
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_cmds.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic char_q_type text(string s);
      char_q_type chars;
      for (int i = 0; i < s.len(); i++) chars.push_back(s[i]);
      return chars;
   endfunction

   function automatic char_q_type make_command_frame();
      char_q_type chars;
      int         limit;
      int         count;
      chars.push_back(CHAR_M);
      if ($urandom_range(0, 4) == 0) chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 15)));
      else chars.push_back(8'(CHAR_ZERO + active_id));
      case ($urandom_range(0, 2))
         0: chars.push_back(CHAR_P);
         1: chars.push_back(CHAR_S);
         default: chars.push_back(CHAR_C);
      endcase
      chars.push_back(CHAR_COLON);
      limit = MAX_VALUE_CHARS_DEFAULT;
      if ($urandom_range(0, 1) == 1) begin
         chars.push_back(CHAR_MINUS);
         limit--;
      end
      count = ($urandom_range(0, 3) == 0) ? limit : $urandom_range(0, limit);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) == 0) chars.push_back(CHAR_POINT);
         else chars.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) != 0) chars.push_back(CHAR_NEWLINE);
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 3)) chars.push_back(8'($urandom_range(0, 255)));
      end
      return chars;
   endfunction

   task automatic run_random_frames(input int budget);
      char_q_type chars;
      int         stop_at;
      int         pick;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         sender_idles    = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         chars = make_command_frame();
         pick  = $urandom_range(0, 9);
         if (pick == 0) begin
            chars.delete();
            repeat ($urandom_range(0, 8)) begin
               if ($urandom_range(0, 7) == 0) send_request(MODE_IDLE, 8'($urandom_range(0, 255)));
               else chars.push_back(8'($urandom_range(0, 255)));
            end
         end else if (pick == 1) begin
            while (chars.size() > $urandom_range(0, 3)) void'(chars.pop_back());
         end else if (pick <= 3) begin
            case ($urandom_range(0, 3))
               0: chars[$urandom_range(0, chars.size() - 1)] = 8'($urandom_range(0, 255));
               1: chars[$urandom_range(0, chars.size() - 1)] = CHAR_MINUS;
               2: chars[$urandom_range(0, chars.size() - 1)] = CHAR_NEWLINE;
               default: chars[$urandom_range(0, chars.size() - 1)] = CHAR_POINT;
            endcase
         end
         send_frame(chars);
      end
   endtask

   task automatic test_directed_frames();
      sender_idles    = 1'b0;
      receiver_stalls = 1'b0;
      send_request(MODE_IDLE, 8'hFF);
      send_frame(text("M1S:-99999.999x"));
      send_frame(text("M1"));
      send_frame(text("M1C:\n"));
      drain();
   endtask

   task automatic test_device_id(input logic [ID_WIDTH-1:0] id);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= id;
      @(negedge clock);
      csr_we    <= 1'b0;
      active_id = id;
      run_random_frames(300);
      drain();
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_device_id(4'd0);
      test_device_id(4'd9);
      test_device_id(4'd15);
      test_device_id(4'd10);
      test_device_id(4'($urandom_range(0, 9)));
      repeat (LATENCY + 8) @(negedge clock);
      if (error_count == 0 && expected_cmds.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: ascii_setpoint_command_parser_unit.f
rtl/ascp_pkg.sv
rtl/ascp_in_stage.sv
rtl/ascp_parse.sv
rtl/ascp_out_stage.sv
rtl/ascii_setpoint_command_parser_unit.sv
rtl/ascp_checker.sv
tb/testbench.sv
